@@ rtl/cdeq_pkg.sv @@
// Shared types and constants for the circular double-ended queue.
package cdeq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 4;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic signed [DataW-1:0]  push_value;
  } cdeq_in_t;

  typedef struct packed {
    logic signed [DataW-1:0]  popped_value;
    status_e                  status;
    logic [OccW-1:0]          occupancy;
  } cdeq_out_t;

  // Broadcast controls to every cell; already qualified (accepted, not refused).
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdeq_ctl_t;

endpackage

@@ rtl/cdeq_cell.sv @@
// One storage cell of the queue chain: an entry and its valid bit.
module cdeq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cdeq_pkg::cdeq_ctl_t              ctl_i,
  input  logic signed [cdeq_pkg::DataW-1:0] push_value_i,
  input  logic signed [cdeq_pkg::DataW-1:0] up_data_i,
  input  logic                             up_valid_i,
  input  logic signed [cdeq_pkg::DataW-1:0] dn_data_i,
  input  logic                             dn_valid_i,
  output logic signed [cdeq_pkg::DataW-1:0] data_o,
  output logic                             valid_o,
  output logic signed [cdeq_pkg::DataW-1:0] rear_tap_o
);
  import cdeq_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic                    valid_q, valid_d;
  logic                    is_rear;
  logic                    is_first_free;

  // Entries stay packed toward cell 0, so the valid bits form a thermometer.
  assign is_rear       = valid_q & ~dn_valid_i;
  assign is_first_free = ~valid_q & up_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctl_i.push_front) begin
      data_d  = up_data_i;
      valid_d = up_valid_i;
    end else if (ctl_i.pop_front) begin
      data_d  = dn_data_i;
      valid_d = dn_valid_i;
    end else if (ctl_i.push_rear && is_first_free) begin
      data_d  = push_value_i;
      valid_d = 1'b1;
    end else if (ctl_i.pop_rear && is_rear) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign valid_o    = valid_q;
  assign rear_tap_o = is_rear ? data_q : '0;

endmodule

@@ rtl/circular_double_ended_queue.sv @@
// Top level of the double-ended queue: cell chain, occupancy count, result register.
//
//  port          dir  width       role
//  ------------  ---  ----------  -----------------------------------------------
//  start         in   1           item request, taken when busy is low
//  busy          out  1           never raised; an item is taken every cycle
//  item_i        in   cdeq_in_t   opcode and push value
//  result_valid_o out 1           one-cycle strobe marking a result item
//  result_o      out  cdeq_out_t  popped value, status, occupancy
//
// One item per clock. The result item is strobed in the cycle after the item is
// taken; all cells shift or load in that same edge, which sets the latency.
// Reset (rst_ni low, asynchronous) empties the queue: valid bits and count clear,
// entry data is left as is. The receiver cannot stall, so nothing backs up.
module circular_double_ended_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cdeq_pkg::cdeq_in_t  item_i,
  output logic                result_valid_o,
  output cdeq_pkg::cdeq_out_t result_o
);
  import cdeq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                    accept;
  logic                    full;
  logic                    empty;
  cdeq_ctl_t               ctl;
  status_e                 status;
  logic [CntW-1:0]         count_q, count_d;
  logic                    res_valid_q;
  cdeq_out_t               res_q, res_d;

  // Chain taps: cell i sees cell i-1 as "up" (toward the front).
  logic signed [DataW-1:0] cell_data  [DEPTH];
  logic signed [DataW-1:0] cell_tap   [DEPTH];
  logic [DEPTH-1:0]        cell_valid;
  logic signed [DataW-1:0] rear_value;
  logic [DEPTH-1:0]        thermo_chk;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // Decode: refused items drive no controls, so the state holds.
  always_comb begin
    ctl    = '0;
    status = ST_DONE;
    case (item_i.opcode)
      OP_PUSH_FRONT: begin
        if (full) status = ST_OVERFLOW;
        else      ctl.push_front = accept;
      end
      OP_PUSH_REAR: begin
        if (full) status = ST_OVERFLOW;
        else      ctl.push_rear = accept;
      end
      OP_POP_FRONT: begin
        if (empty) status = ST_UNDERFLOW;
        else       ctl.pop_front = accept;
      end
      OP_POP_REAR: begin
        if (empty) status = ST_UNDERFLOW;
        else       ctl.pop_rear = accept;
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // At most one cell flags itself as rear (none when empty); OR the taps to pick its entry.
  always_comb begin
    rear_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_value = rear_value | cell_tap[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl.push_front || ctl.push_rear) begin
      count_d = count_q + CntW'(1);
    end else if (ctl.pop_front || ctl.pop_rear) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_d.status       = status;
    res_d.occupancy    = OccW'(count_d);
    res_d.popped_value = '0;
    if (ctl.pop_front) begin
      res_d.popped_value = cell_data[0];
    end else if (ctl.pop_rear) begin
      res_d.popped_value = rear_value;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DataW-1:0] up_data;
    logic                    up_valid;
    logic signed [DataW-1:0] dn_data;
    logic                    dn_valid;

    if (g == 0) begin : g_head
      assign up_data  = item_i.push_value;
      assign up_valid = 1'b1;
    end else begin : g_mid_up
      assign up_data  = cell_data[g-1];
      assign up_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign dn_data  = '0;
      assign dn_valid = 1'b0;
    end else begin : g_mid_dn
      assign dn_data  = cell_data[g+1];
      assign dn_valid = cell_valid[g+1];
    end

    cdeq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .push_value_i (item_i.push_value),
      .up_data_i    (up_data),
      .up_valid_i   (up_valid),
      .dn_data_i    (dn_data),
      .dn_valid_i   (dn_valid),
      .data_o       (cell_data[g]),
      .valid_o      (cell_valid[g]),
      .rear_tap_o   (cell_tap[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Valid bits must stay packed toward cell 0.
  assign thermo_chk = cell_valid & (cell_valid + {{(DEPTH-1){1'b0}}, 1'b1});

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("occupancy count disagrees with cell valid bits");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thermo_chk == '0)
    else $error("cell valid bits not contiguous from the front");

  a_one_result_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("accepted item produced no result strobe");

  a_underflow_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_UNDERFLOW) |-> (count_q == '0))
    else $error("underflow reported while queue holds entries");

  a_overflow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status == ST_OVERFLOW) |-> full)
    else $error("overflow reported while queue has room");

endmodule

@@ dv/circular_double_ended_queue_tb.sv @@
// Self-checking testbench for the circular double-ended queue: directed corners, random mix.
`timescale 1ns / 100ps

module circular_double_ended_queue_tb;
  import cdeq_pkg::*;

  localparam int unsigned QDEPTH   = 8;
  localparam int unsigned TIMEOUT  = 400_000;  // ns, far beyond the slowest legal run
  localparam int unsigned MAX_SHOW = 10;

  localparam logic [DataW-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [DataW-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] VAL_ONES = 32'hFFFF_FFFF;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  cdeq_in_t  item;
  logic      result_valid;
  cdeq_out_t result;

  // Deque state as the block should hold it: circular store, front index,
  // index just past the rear entry, and the fill count.
  logic [DataW-1:0] deque_store [QDEPTH];
  int unsigned      front_idx;
  int unsigned      rear_idx;
  int unsigned      fill_cnt;

  // Results owed by the block, oldest first.
  cdeq_out_t   awaited_results[$];
  cdeq_out_t   owed;
  int unsigned mismatch_cnt;
  int unsigned items_sent;

  circular_double_ended_queue #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one operation to the deque state and returns the result item it owes.
  // A refused push or pop leaves every index and the count alone.
  function automatic cdeq_out_t deque_apply(input cdeq_in_t op_item);
    cdeq_out_t r;
    r.popped_value = '0;
    r.status       = ST_DONE;
    case (op_item.opcode)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (fill_cnt >= QDEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (op_item.opcode == OP_PUSH_FRONT) begin
          front_idx = (front_idx + QDEPTH - 1) % QDEPTH;
          deque_store[front_idx] = op_item.push_value;
          fill_cnt++;
        end else begin
          deque_store[rear_idx] = op_item.push_value;
          rear_idx = (rear_idx + 1) % QDEPTH;
          fill_cnt++;
        end
      end
      default: begin
        if (fill_cnt == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (op_item.opcode == OP_POP_FRONT) begin
          r.popped_value = deque_store[front_idx];
          front_idx = (front_idx + 1) % QDEPTH;
          fill_cnt--;
        end else begin
          rear_idx = (rear_idx + QDEPTH - 1) % QDEPTH;
          r.popped_value = deque_store[rear_idx];
          fill_cnt--;
        end
      end
    endcase
    r.occupancy = OccW'(fill_cnt);
    return r;
  endfunction

  // Drives one item from the falling edge and holds it until taken. start is
  // left high on return so back-to-back items follow without a gap; the next
  // call or a gap decides what the following cycle sees.
  task automatic send_op(input opcode_e op, input logic [DataW-1:0] val);
    cdeq_in_t nxt;
    nxt.opcode     = op;
    nxt.push_value = val;
    @(negedge clk_i);
    start = 1'b1;
    item  = nxt;
    do @(posedge clk_i); while (busy);
    awaited_results.push_back(deque_apply(nxt));
    items_sent++;
  endtask

  // Sender stays quiet, with start low, for the gap given by n.
  task automatic sender_gap(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
    end
  endtask

  // Stop sending and wait for every owed result.
  task automatic drain_results();
    sender_gap(1);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Random push value, leaning on the extremes now and then.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_ONES;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Random op: pushes with the given percent weight, either end chosen evenly.
  function automatic opcode_e pick_op(input int unsigned push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
    return $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  task automatic note_mismatch(input string field, input logic [DataW-1:0] exp_v,
                               input logic [DataW-1:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOW)
      $display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, exp_v, act_v);
  endtask

  // Result checker. Each strobed result is matched with the oldest owed item;
  // a strobe with nothing owed counts as a failure too.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result", '0, result.popped_value);
      end else begin
        owed = awaited_results.pop_front();
        if (result.popped_value !== owed.popped_value)
          note_mismatch("popped_value", owed.popped_value, result.popped_value);
        if (result.status !== owed.status)
          note_mismatch("status", DataW'(owed.status), DataW'(result.status));
        if (result.occupancy !== owed.occupancy)
          note_mismatch("occupancy", DataW'(owed.occupancy), DataW'(result.occupancy));
      end
    end
  end

  // Corners: underflow at both ends on an empty queue, the value extremes
  // through each end, a fill with wrap of the front index, overflow at both
  // ends, then a full drain from both ends and one more underflow. Pops
  // carry all-ones or zero data to show their value field is ignored.
  task automatic test_directed_corners();
    send_op(OP_POP_FRONT,  VAL_ONES);
    send_op(OP_POP_REAR,   VAL_ONES);
    send_op(OP_PUSH_FRONT, VAL_MIN);
    send_op(OP_PUSH_REAR,  VAL_MAX);
    send_op(OP_POP_FRONT,  VAL_ONES);
    send_op(OP_POP_REAR,   '0);
    send_op(OP_PUSH_FRONT, VAL_ONES);
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_PUSH_REAR,  32'hAAAA_AAAA);
    send_op(OP_PUSH_REAR,  32'h5555_5555);
    send_op(OP_PUSH_FRONT, 32'h0000_0001);
    send_op(OP_PUSH_REAR,  VAL_MIN);
    send_op(OP_PUSH_FRONT, VAL_MAX);
    send_op(OP_PUSH_REAR,  32'h1234_5678);
    send_op(OP_PUSH_FRONT, VAL_ONES);      // full: refused
    send_op(OP_PUSH_REAR,  VAL_ONES);      // full: refused
    repeat (4) send_op(OP_POP_REAR, VAL_ONES);
    repeat (4) send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_FRONT,  VAL_ONES);      // empty again: refused
    drain_results();
  endtask

  // Random mix in segments of varying push weight, so the queue keeps
  // swinging between empty and full. Sender gaps of random length fall
  // after random items; some segments end with a full drain.
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned left;
    int unsigned seg_len;
    int unsigned push_pct;
    left = n_items;
    while (left > 0) begin
      seg_len = $urandom_range(60, 15);
      if (seg_len > left) seg_len = left;
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 50;
        default: push_pct = 20;
      endcase
      repeat (seg_len) begin
        send_op(pick_op(push_pct), pick_value());
        if ($urandom_range(5) == 0) sender_gap($urandom_range(10, 1));
      end
      left -= seg_len;
      if ($urandom_range(9) == 0) drain_results();
    end
  endtask

  // Sender holds off until every owed result has come, then resumes.
  task automatic test_drain_pause();
    repeat (6) send_op(pick_op(70), pick_value());
    drain_results();
    repeat (6) send_op(pick_op(30), pick_value());
  endtask

  // Closing stretch: one item every cycle, no gaps.
  task automatic test_back_to_back(input int unsigned n_items);
    int unsigned push_pct;
    repeat (n_items / 40) begin
      push_pct = $urandom_range(85, 15);
      repeat (40) send_op(pick_op(push_pct), pick_value());
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item         = '0;
    front_idx    = 0;
    rear_idx     = 0;
    fill_cnt     = 0;
    mismatch_cnt = 0;
    items_sent   = 0;
    foreach (deque_store[i]) deque_store[i] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_corners();
    test_random_mix(1300);
    test_drain_pause();
    test_random_mix(200);
    test_back_to_back(200);

    drain_results();
    repeat (4) @(posedge clk_i);  // margin before the final check
    if (awaited_results.size() != 0) mismatch_cnt++;

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
